// ===== sv/spmb_pkg.sv =====
// Shared types, constants and helpers of the spectrum peak marker ballistics unit.
package spmb_pkg;

  localparam int BAR_COUNT = 64;
  localparam int IDX_W     = 6;
  localparam int Q_W       = 24;

  localparam logic [IDX_W-1:0] LAST_BAR = IDX_W'(BAR_COUNT - 1);

  localparam logic signed [Q_W-1:0] LEVEL_RESET  = 24'sd4096;
  localparam logic signed [Q_W-1:0] HEIGHT_RESET = 24'sd8192;

  localparam logic [15:0] TIME_STEP_RESET = 16'd68;
  localparam logic [22:0] LAUNCH_RESET    = 23'd40960;
  localparam logic [22:0] GRAVITY_RESET   = 23'd40182;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_LAUNCH    = 2'd1;
  localparam logic [1:0] REG_GRAVITY   = 2'd2;

  typedef struct packed {
    logic [15:0] time_step;
    logic [22:0] launch_speed;
    logic [22:0] gravity;
  } cfg_t;

  typedef struct packed {
    logic             set_we;
    logic             prep;
    logic             round;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             vel;
    logic             mul;
    logic             upd;
    logic [IDX_W-1:0] addr;
    logic             last;
  } cmd_t;

  function automatic logic signed [Q_W-1:0] sat24(input logic signed [29:0] x);
    logic signed [Q_W-1:0] r;
    if (x > 30'sd8388607) begin
      r = 24'sd8388607;
    end else if (x < -30'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/spectrum_peak_marker_ballistics_unit.sv =====
// Top level of the spectrum peak marker ballistics unit.
// Input words are taken on start while busy is low. mode 0 writes the level of
// bar bar_index and completes in the accepting cycle; busy stays low and no
// result is produced. mode 1 starts a tick that walks every bar in order.
// During a tick busy stays high: PREP and ROUND form gravity times time step
// once, then each bar passes through VEL (velocity update), MUL (velocity
// times time step) and UPD (height update and write-back to the marker
// memory).
// Each result (out_index, marker_out, last) is on the ports for one cycle
// with strobe high; it is registered from the UPD state of its bar, so the
// first follows PREP, ROUND, VEL and MUL. last marks the final bar; it shows
// in the first cycle after busy falls. The receiver cannot stall the results.
// APB holds time_step, launch_speed and gravity at byte addresses 0, 4 and 8;
// pready is always high. The user makes writes while idle; it is not enforced.
// Reset restores the register defaults and returns every bar level to 1.0,
// every marker to height 2.0 and velocity zero through per-entry valid bits.
module spectrum_peak_marker_ballistics_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode,
  input  logic [spmb_pkg::IDX_W-1:0]      bar_index,
  input  logic signed [spmb_pkg::Q_W-1:0] level,
  output logic                            strobe,
  output logic [spmb_pkg::IDX_W-1:0]      out_index,
  output logic signed [spmb_pkg::Q_W-1:0] marker_out,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import spmb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  spmb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spmb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .cmd   (cmd)
  );

  spmb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .bar_index  (bar_index),
    .level      (level),
    .strobe     (strobe),
    .out_index  (out_index),
    .marker_out (marker_out),
    .last       (last)
  );

endmodule

// ===== sv/spmb_regs.sv =====
// APB configuration registers: time step, launch speed and gravity.
module spmb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output spmb_pkg::cfg_t      cfg
);
  import spmb_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step    <= TIME_STEP_RESET;
      cfg.launch_speed <= LAUNCH_RESET;
      cfg.gravity      <= GRAVITY_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_TIME_STEP: cfg.time_step    <= pwdata[15:0];
        REG_LAUNCH:    cfg.launch_speed <= pwdata[22:0];
        REG_GRAVITY:   cfg.gravity      <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIME_STEP: prdata = {16'd0, cfg.time_step};
      REG_LAUNCH:    prdata = {9'd0, cfg.launch_speed};
      REG_GRAVITY:   prdata = {9'd0, cfg.gravity};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/spmb_ctrl.sv =====
// Sequencer: decodes words, walks the bars of a tick and issues datapath commands.
module spmb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode,
  output logic           busy,
  output spmb_pkg::cmd_t cmd
);
  import spmb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_VEL   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             is_last;

  assign is_last = (idx == LAST_BAR);
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (start && mode) begin
          state_next = S_PREP;
          idx_next   = '0;
        end
      end
      S_PREP:  state_next = S_ROUND;
      S_ROUND: state_next = S_VEL;
      S_VEL:   state_next = S_MUL;
      S_MUL:   state_next = S_UPD;
      S_UPD: begin
        if (is_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_VEL;
          idx_next   = IDX_W'(idx + 1'b1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    cmd.set_we  = (state == S_IDLE) & start & ~mode;
    cmd.prep    = (state == S_PREP);
    cmd.round   = (state == S_ROUND);
    cmd.rd_en   = (state == S_ROUND) | (state == S_MUL);
    cmd.rd_addr = (state == S_ROUND) ? '0 : IDX_W'(idx + 1'b1);
    cmd.vel     = (state == S_VEL);
    cmd.mul     = (state == S_MUL);
    cmd.upd     = (state == S_UPD);
    cmd.addr    = idx;
    cmd.last    = is_last;
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && mode) |=> (state == S_PREP && idx == '0))
    else $error("tick word did not start the walk at the first bar");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && is_last) |=> (state == S_IDLE))
    else $error("walk did not end after the final bar");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && !is_last) |=> (state == S_VEL && idx == $past(idx) + 1'b1))
    else $error("walk skipped or repeated a bar");

endmodule

// ===== sv/spmb_dp.sv =====
// Datapath: bar and marker memories, ballistics arithmetic and result register.
module spmb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  spmb_pkg::cmd_t                cmd,
  input  spmb_pkg::cfg_t                cfg,
  input  logic [spmb_pkg::IDX_W-1:0]    bar_index,
  input  logic signed [spmb_pkg::Q_W-1:0] level,
  output logic                          strobe,
  output logic [spmb_pkg::IDX_W-1:0]    out_index,
  output logic signed [spmb_pkg::Q_W-1:0] marker_out,
  output logic                          last
);
  import spmb_pkg::*;

  logic signed [Q_W-1:0]   lvl_mem [BAR_COUNT];
  logic [2*Q_W-1:0]        mk_mem  [BAR_COUNT];
  logic [BAR_COUNT-1:0]    lvl_valid;
  logic [BAR_COUNT-1:0]    mk_valid;

  logic signed [Q_W-1:0]   rd_level;
  logic [2*Q_W-1:0]        rd_mk;
  logic                    rd_lvl_ok;
  logic                    rd_mk_ok;

  logic [38:0]             dv_prod;
  logic [27:0]             dv;
  logic signed [Q_W-1:0]   h_hold;
  logic signed [Q_W-1:0]   v_hold;
  logic signed [40:0]      prod;

  logic signed [Q_W-1:0]   lvl_eff;
  logic signed [Q_W-1:0]   h_eff;
  logic signed [Q_W-1:0]   vel_eff;
  logic signed [29:0]      vdiff;
  logic signed [Q_W-1:0]   v_calc;
  logic [40:0]             prnd;
  logic signed [29:0]      hsum;
  logic signed [Q_W-1:0]   h_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= '0;
    end else if (cmd.set_we && ({1'b0, bar_index} < 7'(BAR_COUNT))) begin
      lvl_valid[bar_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_we && ({1'b0, bar_index} < 7'(BAR_COUNT))) begin
      lvl_mem[bar_index] <= level;
    end
    if (cmd.rd_en) begin
      rd_level  <= lvl_mem[cmd.rd_addr];
      rd_lvl_ok <= lvl_valid[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mk_valid <= '0;
    end else if (cmd.upd) begin
      mk_valid[cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mk_mem[cmd.addr] <= {h_new, v_hold};
    end
    if (cmd.rd_en) begin
      rd_mk    <= mk_mem[cmd.rd_addr];
      rd_mk_ok <= mk_valid[cmd.rd_addr];
    end
  end

  assign lvl_eff = rd_lvl_ok ? rd_level : LEVEL_RESET;
  assign h_eff   = rd_mk_ok ? $signed(rd_mk[2*Q_W-1:Q_W]) : HEIGHT_RESET;
  assign vel_eff = rd_mk_ok ? $signed(rd_mk[Q_W-1:0]) : '0;

  assign vdiff  = $signed({{6{vel_eff[Q_W-1]}}, vel_eff}) - $signed({2'b00, dv});
  assign v_calc = (h_eff <= lvl_eff) ? $signed({1'b0, cfg.launch_speed}) : sat24(vdiff);

  assign prnd  = prod + 41'd2048;
  assign hsum  = $signed({{6{h_hold[Q_W-1]}}, h_hold}) + $signed({prnd[40], prnd[40:12]});
  assign h_new = sat24(hsum);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dv_prod <= {16'd0, cfg.gravity} * {23'd0, cfg.time_step};
    end
    if (cmd.round) begin
      dv <= 28'((dv_prod + 39'd2048) >> 12);
    end
    if (cmd.vel) begin
      h_hold <= h_eff;
      v_hold <= v_calc;
    end
    if (cmd.mul) begin
      prod <= $signed({{17{v_hold[Q_W-1]}}, v_hold}) * $signed({25'd0, cfg.time_step});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_index  <= cmd.addr;
      marker_out <= h_new;
      last       <= cmd.last;
    end
  end

endmodule

// ===== dv/spectrum_peak_marker_ballistics_unit_tb.sv =====
// Self-checking testbench: drives set and tick words, predicts every marker height, checks results.
`timescale 1ns / 100ps

module spectrum_peak_marker_ballistics_unit_tb;
  import spmb_pkg::*;

  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic                  mode;
    logic [IDX_W-1:0]      bar;
    logic signed [Q_W-1:0] lvl;
  } bar_word_t;

  typedef struct {
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] height;
    logic                  is_last;
  } peak_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  mode = MODE_SET;
  logic [IDX_W-1:0]      bar_index = '0;
  logic signed [Q_W-1:0] level = '0;
  logic                  strobe;
  logic [IDX_W-1:0]      out_index;
  logic signed [Q_W-1:0] marker_out;
  logic                  last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [3:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bar_word_t pending_words[$];
  peak_t     peak_q[$];
  bar_word_t drv_word;
  peak_t     want;

  logic signed [Q_W-1:0] bar_lvl[BAR_COUNT];
  logic signed [Q_W-1:0] mk_height[BAR_COUNT];
  logic signed [Q_W-1:0] mk_vel[BAR_COUNT];
  logic [15:0]           cfg_step;
  logic [22:0]           cfg_launch;
  logic [22:0]           cfg_gravity;

  int err_cnt = 0;
  int n_pushed = 0;
  int n_taken = 0;
  int gap_pct = 6;

  spectrum_peak_marker_ballistics_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .bar_index(bar_index), .level(level),
    .strobe(strobe), .out_index(out_index), .marker_out(marker_out), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string msg);
    if (err_cnt < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  function automatic logic signed [Q_W-1:0] clip24(input logic signed [63:0] x);
    logic signed [Q_W-1:0] r;
    if (x > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (x < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[Q_W-1:0];
    end
    return r;
  endfunction

  // Q.24 product back to Q.12: round to nearest, ties upward
  function automatic logic signed [63:0] round_q12(input logic signed [63:0] p);
    return (p + 64'sd2048) >>> 12;
  endfunction

  function automatic void advance_markers(input logic md, input logic [IDX_W-1:0] bi,
                                          input logic signed [Q_W-1:0] lv);
    logic signed [63:0] step64;
    logic signed [63:0] launch64;
    logic signed [63:0] grav64;
    logic signed [63:0] dv;
    logic signed [63:0] v64;
    logic signed [63:0] h64;
    logic signed [Q_W-1:0] v;
    logic signed [Q_W-1:0] h;
    peak_t p;
    if (md == MODE_SET) begin
      bar_lvl[bi] = lv;
    end else begin
      step64   = cfg_step;
      launch64 = cfg_launch;
      grav64   = cfg_gravity;
      dv       = round_q12(grav64 * step64);
      for (int i = 0; i < BAR_COUNT; i++) begin
        h = mk_height[i];
        if (h <= bar_lvl[i]) begin
          v = clip24(launch64);
        end else begin
          v64 = mk_vel[i];
          v = clip24(v64 - dv);
        end
        mk_vel[i] = v;
        v64 = v;
        h64 = h;
        h = clip24(h64 + round_q12(v64 * step64));
        mk_height[i] = h;
        p.idx     = IDX_W'(i);
        p.height  = h;
        p.is_last = (i == BAR_COUNT - 1);
        peak_q.insert(peak_q.size(), p);
      end
    end
  endfunction

  task automatic push_word(input logic md, input logic [IDX_W-1:0] bi,
                           input logic signed [Q_W-1:0] lv);
    bar_word_t w;
    w.mode = md;
    w.bar  = bi;
    w.lvl  = lv;
    pending_words.insert(pending_words.size(), w);
    n_pushed++;
  endtask

  task automatic push_random(input int count);
    logic signed [Q_W-1:0] lv;
    logic [IDX_W-1:0] bi;
    for (int k = 0; k < count; k++) begin
      bi = IDX_W'($urandom_range(BAR_COUNT - 1));
      if ($urandom_range(9) < 6) begin
        lv = Q_W'(int'($urandom_range(0, 131071)) - 65536);
      end else begin
        lv = Q_W'($urandom);
      end
      if ($urandom_range(99) < 30) begin
        push_word(MODE_TICK, bi, lv);
      end else begin
        push_word(MODE_SET, bi, lv);
      end
    end
  endtask

  task automatic drain();
    while (n_taken != n_pushed || peak_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] reg_idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_TIME_STEP: cfg_step    = data[15:0];
      REG_LAUNCH:    cfg_launch  = data[22:0];
      REG_GRAVITY:   cfg_gravity = data[22:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_markers(mode, bar_index, level);
        n_taken++;
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          drv_word = pending_words.pop_front();
          start     <= 1'b1;
          mode      <= drv_word.mode;
          bar_index <= drv_word.bar;
          level     <= drv_word.lvl;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (peak_q.size() == 0) begin
        report($sformatf("unexpected word index=%0d height=%0d last=%0b",
                         out_index, marker_out, last));
      end else begin
        want = peak_q.pop_front();
        if (out_index !== want.idx) begin
          report($sformatf("out_index got %0d want %0d", out_index, want.idx));
        end
        if (marker_out !== want.height) begin
          report($sformatf("marker_out bar %0d got %0d want %0d",
                           want.idx, marker_out, want.height));
        end
        if (last !== want.is_last) begin
          report($sformatf("last bar %0d got %0b want %0b", want.idx, last, want.is_last));
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < BAR_COUNT; i++) begin
      bar_lvl[i]   = LEVEL_RESET;
      mk_height[i] = HEIGHT_RESET;
      mk_vel[i]    = '0;
    end
    cfg_step    = TIME_STEP_RESET;
    cfg_launch  = LAUNCH_RESET;
    cfg_gravity = GRAVITY_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, field extremes, ignored fields on tick
    gap_pct = 6;
    push_word(MODE_TICK, '0, '0);
    push_word(MODE_SET, 6'd0, 24'sh7FFFFF);
    push_word(MODE_SET, 6'd63, 24'sh800000);
    push_word(MODE_SET, 6'd2, 24'sd0);
    push_word(MODE_SET, 6'd42, 24'sh555555);
    push_word(MODE_SET, 6'd21, 24'shAAAAAA);
    push_word(MODE_TICK, 6'd63, -24'sd1);
    push_word(MODE_TICK, 6'd0, 24'sh7FFFFF);
    push_word(MODE_SET, 6'd0, 24'sh800000);
    push_word(MODE_SET, 6'd63, 24'sh7FFFFF);
    push_word(MODE_TICK, 6'h2A, 24'sh800000);
    push_word(MODE_TICK, 6'h15, 24'sh2AAAAA);
    drain();
    // marker exactly at its bar
    push_word(MODE_SET, 6'd3, mk_height[3]);
    push_word(MODE_SET, 6'd60, mk_height[60]);
    push_word(MODE_TICK, '0, '0);
    push_word(MODE_TICK, '0, '0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          cfg_write(REG_TIME_STEP, 32'h0000FFFF);
          cfg_write(REG_LAUNCH, 32'h007FFFFF);
          cfg_write(REG_GRAVITY, 32'h00000000);
          cfg_write(REG_UNUSED, $urandom);
        end
        2: begin
          cfg_write(REG_TIME_STEP, 32'h00000000);
          cfg_write(REG_LAUNCH, 32'h00000000);
          cfg_write(REG_GRAVITY, 32'h007FFFFF);
        end
        3: begin
          cfg_write(REG_TIME_STEP, $urandom);
          cfg_write(REG_LAUNCH, $urandom);
          cfg_write(REG_GRAVITY, $urandom);
        end
        4: begin
          cfg_write(REG_TIME_STEP, $urandom_range(16, 400));
          cfg_write(REG_LAUNCH, $urandom_range(0, 200000));
          cfg_write(REG_GRAVITY, $urandom_range(0, 200000));
        end
        default: ;
      endcase
      gap_pct = (ph < 2) ? 6 : (ph < 4) ? 50 : 0;
      push_random(76);
      drain();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
